// ----- rtl/core/cdtn_pkg.sv -----
package cdtn_pkg;

  // Field widths of one input beat
  localparam int unsigned InDayW    = 10;
  localparam int unsigned InMonthW  = 8;
  localparam int unsigned YearW     = 14;
  localparam int unsigned InHourW   = 10;
  localparam int unsigned InMinuteW = 16;

  // Field widths of one output beat
  localparam int unsigned OutDayW    = 5;
  localparam int unsigned OutMonthW  = 4;
  localparam int unsigned OutHourW   = 5;
  localparam int unsigned OutMinuteW = 6;

  // Internal widths after the carries
  localparam int unsigned WorkDayW  = 11;  // up to 1023 + 88
  localparam int unsigned HourSumW  = 12;  // up to 1023 + 1092
  localparam int unsigned QMinW     = 11;  // minute / 60, up to 1092
  localparam int unsigned QHourW    = 7;   // hour / 24, up to 88
  localparam int unsigned QMonW     = 5;   // (month - 1) / 12, up to 21
  localparam int unsigned QYearW    = 6;   // year / 400, up to 40
  localparam int unsigned YearRemW  = 9;   // year % 400

  // Reciprocal constants: floor(x / d) = (x * M) >> S over the whole input range
  localparam int unsigned MinRecipM  = 69906;
  localparam int unsigned MinRecipS  = 22;
  localparam int unsigned HourRecipM = 5462;
  localparam int unsigned HourRecipS = 17;
  localparam int unsigned MonRecipM  = 342;
  localparam int unsigned MonRecipS  = 12;
  localparam int unsigned YearRecipM = 20972;
  localparam int unsigned YearRecipS = 23;

  // Calendar constants
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned HourPerDay  = 24;
  localparam int unsigned MonPerYear  = 12;
  localparam int unsigned LeapFebDays = 29;
  localparam int unsigned Century     = 100;
  localparam int unsigned LeapCycle   = 400;
  localparam logic [YearW-1:0] YearMax = {YearW{1'b1}};

  // Queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [InDayW-1:0]    in_day;
    logic [InMonthW-1:0]  in_month;
    logic [YearW-1:0]     in_year;
    logic [InHourW-1:0]   in_hour;
    logic [InMinuteW-1:0] in_minute;
  } in_t;

  typedef struct packed {
    logic [OutDayW-1:0]    out_day;
    logic [OutMonthW-1:0]  out_month;
    logic [YearW-1:0]      out_year;
    logic [OutHourW-1:0]   out_hour;
    logic [OutMinuteW-1:0] out_minute;
  } out_t;

  // Item after the time carries and month fold, before the day walk
  typedef struct packed {
    logic [WorkDayW-1:0]   day;
    logic [OutMonthW-1:0]  month;
    logic [YearW-1:0]      year;
    logic [OutHourW-1:0]   hour;
    logic [OutMinuteW-1:0] minute;
  } work_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MIN,
    F_HOUR,
    F_HDIV,
    F_DAY,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YDIV,
    B_YREM,
    B_WALK
  } back_state_e;

  // Days in a month; February handled with the leap flag
  function automatic logic [OutDayW-1:0] month_days(logic [OutMonthW-1:0] month,
                                                    logic leap);
    logic [OutDayW-1:0] d;
    begin
      unique case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
        4'd2:    d = leap ? OutDayW'(LeapFebDays) : 5'd28;
        default: d = 5'd0;
      endcase
      return d;
    end
  endfunction

endpackage

// ----- rtl/core/calendar_date_time_normalizer_top.sv -----
// Gregorian date and time normalizer. Each input beat carries a day, month, year, hour and
// minute that may overflow; each output beat is the same instant with minute 0..59, hour
// 0..23, month 1..12 and the day within its month (a zero day stays zero, and a zero month
// then stays zero). A front end takes a new beat only after it has pushed the last one; it
// works out the minute and hour carries and the month-to-year fold by reciprocal multiplies
// and hands the item through a short queue to the back end. The back end takes an item only
// when idle, locates the year in the 400-year leap cycle (states B_YDIV and B_YREM), then
// walks off excess days one month per cycle (up to 36 months) and loads the output register,
// which a stalled output holds. Throughput is therefore set by the back end's month walk
// for long walks and by the front end for short ones.
module calendar_date_time_normalizer_top #(
  parameter int unsigned QueueDepth = cdtn_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cdtn_pkg::in_t  in_item_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output cdtn_pkg::out_t out_item_o,
  input  logic           out_stall_i
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  cdtn_pkg::work_t push_data;
  cdtn_pkg::work_t pop_data;

  // Accept a beat, carry the time fields and fold the months
  cdtn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Decouple front and back
  cdtn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Walk off excess days
  cdtn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ----- rtl/core/cdtn_front.sv -----
module cdtn_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cdtn_pkg::in_t  in_item_i,
  output logic           in_stall_o,
  output logic           push_o,
  output cdtn_pkg::work_t push_data_o,
  input  logic           full_i
);

  cdtn_pkg::front_state_e state_q, state_d;

  logic [cdtn_pkg::InMinuteW-1:0] min_q, min_d;
  logic [cdtn_pkg::HourSumW-1:0]  hour_q, hour_d;
  logic [cdtn_pkg::WorkDayW-1:0]  day_q, day_d;
  logic [cdtn_pkg::InMonthW-1:0]  mon_q, mon_d;
  logic [cdtn_pkg::YearW-1:0]     year_q, year_d;
  logic [cdtn_pkg::QMinW-1:0]     qmin_q, qmin_d;
  logic [cdtn_pkg::QHourW-1:0]    qhr_q, qhr_d;
  logic [cdtn_pkg::QMonW-1:0]     qmon_q, qmon_d;

  logic                           accept;
  logic [cdtn_pkg::InMonthW-1:0]  mon_m1;
  logic [32:0]                    min_prod;
  logic [16:0]                    mon_prod;
  logic [24:0]                    hour_prod;
  logic [cdtn_pkg::OutMonthW-1:0] push_month;

  assign accept = in_valid_i && !in_stall_o;
  assign mon_m1 = mon_q - 8'd1;

  // Reciprocal products for the constant divisions
  assign min_prod  = 33'(min_q) * 33'(cdtn_pkg::MinRecipM);
  assign mon_prod  = 17'(mon_m1) * 17'(cdtn_pkg::MonRecipM);
  assign hour_prod = 25'(hour_q) * 25'(cdtn_pkg::HourRecipM);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdtn_pkg::F_IDLE: if (in_valid_i) state_d = cdtn_pkg::F_MIN;
      cdtn_pkg::F_MIN:  state_d = cdtn_pkg::F_HOUR;
      cdtn_pkg::F_HOUR: state_d = cdtn_pkg::F_HDIV;
      cdtn_pkg::F_HDIV: state_d = cdtn_pkg::F_DAY;
      cdtn_pkg::F_DAY:  state_d = cdtn_pkg::F_PUSH;
      cdtn_pkg::F_PUSH: if (!full_i) state_d = cdtn_pkg::F_IDLE;
      default:          state_d = cdtn_pkg::F_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall_o = (state_q != cdtn_pkg::F_IDLE);
    push_o     = (state_q == cdtn_pkg::F_PUSH) && !full_i;
  end

  // Datapath: constant divisions and carries, stepped through the states
  always_comb begin
    min_d  = min_q;
    hour_d = hour_q;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    qmin_d = qmin_q;
    qhr_d  = qhr_q;
    qmon_d = qmon_q;
    unique case (state_q)
      cdtn_pkg::F_IDLE: begin
        if (accept) begin
          min_d  = in_item_i.in_minute;
          hour_d = cdtn_pkg::HourSumW'(in_item_i.in_hour);
          day_d  = cdtn_pkg::WorkDayW'(in_item_i.in_day);
          mon_d  = in_item_i.in_month;
          year_d = in_item_i.in_year;
        end
      end
      cdtn_pkg::F_MIN: begin
        qmin_d = min_prod[cdtn_pkg::MinRecipS +: cdtn_pkg::QMinW];
        qmon_d = mon_prod[cdtn_pkg::MonRecipS +: cdtn_pkg::QMonW];
      end
      cdtn_pkg::F_HOUR: begin
        min_d  = min_q - 16'(16'(qmin_q) * 16'(cdtn_pkg::MinPerHour));
        hour_d = hour_q + cdtn_pkg::HourSumW'(qmin_q);
        // fold months above twelve into the year
        if (mon_q > 8'(cdtn_pkg::MonPerYear)) begin
          year_d = year_q + cdtn_pkg::YearW'(qmon_q);
          mon_d  = mon_m1 - 8'(8'(qmon_q) * 8'(cdtn_pkg::MonPerYear)) + 8'd1;
        end
      end
      cdtn_pkg::F_HDIV: begin
        qhr_d = hour_prod[cdtn_pkg::HourRecipS +: cdtn_pkg::QHourW];
      end
      cdtn_pkg::F_DAY: begin
        hour_d = hour_q - 12'(12'(qhr_q) * 12'(cdtn_pkg::HourPerDay));
        day_d  = day_q + cdtn_pkg::WorkDayW'(qhr_q);
      end
      cdtn_pkg::F_PUSH: ;
      default: ;
    endcase
  end

  // Month zero steps to January when there is a day to walk
  assign push_month = (mon_q == 8'd0 && day_q != '0) ? 4'd1 : mon_q[cdtn_pkg::OutMonthW-1:0];

  always_comb begin
    push_data_o.day    = day_q;
    push_data_o.month  = push_month;
    push_data_o.year   = year_q;
    push_data_o.hour   = hour_q[cdtn_pkg::OutHourW-1:0];
    push_data_o.minute = min_q[cdtn_pkg::OutMinuteW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdtn_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    hour_q <= hour_d;
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    qmin_q <= qmin_d;
    qhr_q  <= qhr_d;
    qmon_q <= qmon_d;
  end

endmodule

// ----- rtl/core/cdtn_queue.sv -----
module cdtn_queue #(
  parameter int unsigned Depth = cdtn_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cdtn_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output cdtn_pkg::work_t pop_data_o,
  output logic            empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  cdtn_pkg::work_t mem_q [Depth];

  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/core/cdtn_back.sv -----
module cdtn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  cdtn_pkg::work_t pop_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output cdtn_pkg::out_t  out_item_o,
  input  logic            out_stall_i
);

  cdtn_pkg::back_state_e state_q, state_d;

  logic [cdtn_pkg::WorkDayW-1:0]   day_q, day_d;
  logic [cdtn_pkg::OutMonthW-1:0]  mon_q, mon_d;
  logic [cdtn_pkg::YearW-1:0]      year_q, year_d;
  logic [cdtn_pkg::OutHourW-1:0]   hour_q, hour_d;
  logic [cdtn_pkg::OutMinuteW-1:0] min_q, min_d;
  logic [cdtn_pkg::QYearW-1:0]     qyr_q, qyr_d;
  logic [cdtn_pkg::YearRemW-1:0]   r400_q, r400_d;

  logic           out_valid_q, out_valid_d;
  cdtn_pkg::out_t out_q, out_d;

  logic [28:0]                  year_prod;
  logic                         leap;
  logic [cdtn_pkg::OutDayW-1:0] dim;
  logic                         step;
  logic                         out_free;
  logic                         finish;

  assign year_prod = 29'(year_q) * 29'(cdtn_pkg::YearRecipM);

  // Leap status from the year's place in the 400-year cycle
  assign leap = (r400_q[1:0] == 2'b00)
             && (r400_q != 9'(cdtn_pkg::Century))
             && (r400_q != 9'(2 * cdtn_pkg::Century))
             && (r400_q != 9'(3 * cdtn_pkg::Century));
  assign dim  = cdtn_pkg::month_days(mon_q, leap);
  assign step = (day_q != '0) && (day_q > cdtn_pkg::WorkDayW'(dim));

  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == cdtn_pkg::B_WALK) && !step && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdtn_pkg::B_IDLE: if (!empty_i) state_d = cdtn_pkg::B_YDIV;
      cdtn_pkg::B_YDIV: state_d = cdtn_pkg::B_YREM;
      cdtn_pkg::B_YREM: state_d = cdtn_pkg::B_WALK;
      cdtn_pkg::B_WALK: if (finish) state_d = cdtn_pkg::B_IDLE;
      default:          state_d = cdtn_pkg::B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o = (state_q == cdtn_pkg::B_IDLE) && !empty_i;
  end

  // Datapath: load, locate the year in the 400-year cycle, then walk one month per cycle
  always_comb begin
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    hour_d = hour_q;
    min_d  = min_q;
    qyr_d  = qyr_q;
    r400_d = r400_q;
    unique case (state_q)
      cdtn_pkg::B_IDLE: begin
        if (!empty_i) begin
          day_d  = pop_data_i.day;
          mon_d  = pop_data_i.month;
          year_d = pop_data_i.year;
          hour_d = pop_data_i.hour;
          min_d  = pop_data_i.minute;
        end
      end
      cdtn_pkg::B_YDIV: begin
        qyr_d = year_prod[cdtn_pkg::YearRecipS +: cdtn_pkg::QYearW];
      end
      cdtn_pkg::B_YREM: begin
        r400_d = cdtn_pkg::YearRemW'(year_q
               - cdtn_pkg::YearW'(cdtn_pkg::YearW'(qyr_q) * cdtn_pkg::YearW'(cdtn_pkg::LeapCycle)));
      end
      cdtn_pkg::B_WALK: begin
        if (step) begin
          day_d = day_q - cdtn_pkg::WorkDayW'(dim);
          if (mon_q == 4'(cdtn_pkg::MonPerYear)) begin
            mon_d  = 4'd1;
            year_d = year_q + 1'b1;
            // the 14-bit year wraps to zero, which starts a new cycle
            if (year_q == cdtn_pkg::YearMax ||
                r400_q == 9'(cdtn_pkg::LeapCycle - 1)) begin
              r400_d = '0;
            end else begin
              r400_d = r400_q + 1'b1;
            end
          end else begin
            mon_d = mon_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (finish) begin
      out_valid_d        = 1'b1;
      out_d.out_day      = day_q[cdtn_pkg::OutDayW-1:0];
      out_d.out_month    = mon_q;
      out_d.out_year     = year_q;
      out_d.out_hour     = hour_q;
      out_d.out_minute   = min_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdtn_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    qyr_q  <= qyr_d;
    r400_q <= r400_d;
    out_q  <= out_d;
  end

endmodule

// ----- rtl/core/cdtn_checker.sv -----
module cdtn_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input cdtn_pkg::in_t  in_item_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input cdtn_pkg::out_t out_item_o,
  input logic           out_stall_i
);

  // A stalled input beat stays offered with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input beat changed while stalled");

  // A stalled output beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output payload changed while stalled");

  // Minute, hour and month lie in their normal ranges, and a February day is at most 29
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_minute < 6'd60) && (out_item_o.out_hour < 5'd24)
                 && (out_item_o.out_month <= 4'd12)
                 && (out_item_o.out_month != 4'd2 || out_item_o.out_day <= 5'd29))
    else $error("output field out of range");

  // A zero month comes only with a zero day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.out_month == 4'd0) |-> (out_item_o.out_day == 5'd0))
    else $error("zero month with nonzero day");

endmodule

bind calendar_date_time_normalizer_top cdtn_checker u_cdtn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_item_i   (in_item_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o),
  .out_stall_i (out_stall_i)
);

// ----- verif/tb_calendar_date_time_normalizer_top.sv -----
`timescale 1ns / 100ps

module tb_calendar_date_time_normalizer_top;

  localparam int unsigned QuietLimit = 2000;  // cycles with no beat on either side
  localparam int unsigned DrainCycles = 100;  // settle time after the last result
  localparam int unsigned MaxReports = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  cdtn_pkg::in_t in_item_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  cdtn_pkg::out_t out_item_o;
  logic out_stall_i = 1'b0;

  cdtn_pkg::in_t pending_q[$];
  cdtn_pkg::out_t instant_q[$];
  int unsigned err_cnt = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned quiet_cycles = 0;
  logic idle_on = 1'b1;

  calendar_date_time_normalizer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Normalize one instant: time carries, month fold, then the month-by-month day walk
  function automatic cdtn_pkg::out_t normalize_instant(cdtn_pkg::in_t b);
    int unsigned day, month, year, hour, minute, dim;
    logic leap;
    cdtn_pkg::out_t r;
    minute = b.in_minute;
    hour   = b.in_hour + minute / cdtn_pkg::MinPerHour;
    minute = minute % cdtn_pkg::MinPerHour;
    day    = b.in_day + hour / cdtn_pkg::HourPerDay;
    hour   = hour % cdtn_pkg::HourPerDay;
    month  = b.in_month;
    year   = b.in_year;
    if (month > cdtn_pkg::MonPerYear) begin
      year  = (year + (month - 1) / cdtn_pkg::MonPerYear) % (1 << cdtn_pkg::YearW);
      month = (month - 1) % cdtn_pkg::MonPerYear + 1;
    end
    if (month == 0 && day > 0) month = 1;
    while (day > 0) begin
      leap = ((year % 4 == 0) && (year % cdtn_pkg::Century != 0))
          || (year % cdtn_pkg::LeapCycle == 0);
      case (month)
        1, 3, 5, 7, 8, 10, 12: dim = 31;
        4, 6, 9, 11:           dim = 30;
        2:                     dim = leap ? cdtn_pkg::LeapFebDays : 28;
        default:               dim = 0;
      endcase
      if (day <= dim) break;
      day   = day - dim;
      month = month + 1;
      if (month > cdtn_pkg::MonPerYear) begin
        month = 1;
        year  = (year + 1) % (1 << cdtn_pkg::YearW);
      end
    end
    r.out_day    = cdtn_pkg::OutDayW'(day);
    r.out_month  = cdtn_pkg::OutMonthW'(month);
    r.out_year   = cdtn_pkg::YearW'(year);
    r.out_hour   = cdtn_pkg::OutHourW'(hour);
    r.out_minute = cdtn_pkg::OutMinuteW'(minute);
    return r;
  endfunction

  function automatic cdtn_pkg::in_t make_item(int unsigned day, int unsigned month,
                                              int unsigned year, int unsigned hour,
                                              int unsigned minute);
    cdtn_pkg::in_t b;
    b.in_day    = cdtn_pkg::InDayW'(day);
    b.in_month  = cdtn_pkg::InMonthW'(month);
    b.in_year   = cdtn_pkg::YearW'(year);
    b.in_hour   = cdtn_pkg::InHourW'(hour);
    b.in_minute = cdtn_pkg::InMinuteW'(minute);
    return b;
  endfunction

  // Random beat: plausible dates, overflow, full range or month edges, in falling shares
  function automatic cdtn_pkg::in_t random_item();
    int unsigned kind, yr, mo, mlen;
    int unsigned edge_years[8] = '{0, 1900, 2000, 2023, 2024, 2100, 2400, 9999};
    kind = $urandom_range(0, 9);
    yr = ($urandom_range(0, 3) == 0) ? edge_years[$urandom_range(0, 7)]
                                     : $urandom_range(0, 9999);
    if (kind <= 3) begin
      return make_item($urandom_range(0, 31), $urandom_range(1, 12), yr,
                       $urandom_range(0, 23), $urandom_range(0, 59));
    end else if (kind <= 6) begin
      return make_item($urandom_range(0, 400), $urandom_range(0, 40), yr,
                       $urandom_range(0, 100), $urandom_range(0, 2000));
    end else if (kind <= 8) begin
      return make_item($urandom_range(0, 1023), $urandom_range(0, 255),
                       $urandom_range(0, 9999), $urandom_range(0, 1023),
                       $urandom_range(0, 65535));
    end
    mo = $urandom_range(1, 12);
    mlen = (mo == 2) ? 28 : ((mo == 4 || mo == 6 || mo == 9 || mo == 11) ? 30 : 31);
    return make_item(mlen + $urandom_range(0, 2), mo, yr, $urandom_range(22, 24),
                     $urandom_range(58, 61));
  endfunction

  // Drive input beats; hold the payload while stalled, insert idle bursts between beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) instant_q.push_back(normalize_instant(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_item_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each output beat against the oldest expected instant; stall in random bursts
  always @(posedge clk_i) begin
    cdtn_pkg::out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (instant_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < MaxReports)
            $display("unexpected beat: day %0d month %0d year %0d hour %0d minute %0d",
                     out_item_o.out_day, out_item_o.out_month, out_item_o.out_year,
                     out_item_o.out_hour, out_item_o.out_minute);
        end else begin
          want = instant_q.pop_front();
          if (out_item_o.out_day !== want.out_day || out_item_o.out_month !== want.out_month ||
              out_item_o.out_year !== want.out_year || out_item_o.out_hour !== want.out_hour ||
              out_item_o.out_minute !== want.out_minute) begin
            err_cnt <= err_cnt + 1;
            if (err_cnt < MaxReports)
              $display("mismatch: exp %0d/%0d/%0d %0d:%0d got %0d/%0d/%0d %0d:%0d",
                       want.out_day, want.out_month, want.out_year, want.out_hour,
                       want.out_minute, out_item_o.out_day, out_item_o.out_month,
                       out_item_o.out_year, out_item_o.out_hour, out_item_o.out_minute);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // End the run when neither side has moved a beat for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Directed beats: extremes, carries, leap rules, folds, zero day and zero month
    pending_q.push_back(make_item(0, 0, 0, 0, 0));
    pending_q.push_back(make_item(0, 5, 2024, 12, 30));
    pending_q.push_back(make_item(0, 200, 1999, 3, 4));
    pending_q.push_back(make_item(0, 0, 2020, 24, 0));
    pending_q.push_back(make_item(15, 0, 2021, 10, 10));
    pending_q.push_back(make_item(1023, 255, 9999, 1023, 65535));
    pending_q.push_back(make_item(1023, 0, 0, 0, 0));
    pending_q.push_back(make_item(31, 12, 1999, 23, 60));
    pending_q.push_back(make_item(31, 12, 9999, 23, 60));
    pending_q.push_back(make_item(29, 2, 2024, 0, 0));
    pending_q.push_back(make_item(29, 2, 2023, 0, 0));
    pending_q.push_back(make_item(29, 2, 1900, 0, 0));
    pending_q.push_back(make_item(29, 2, 2000, 0, 0));
    pending_q.push_back(make_item(29, 2, 2100, 0, 0));
    pending_q.push_back(make_item(29, 2, 0, 0, 0));
    pending_q.push_back(make_item(28, 2, 2400, 24, 0));
    pending_q.push_back(make_item(10, 12, 2001, 5, 5));
    pending_q.push_back(make_item(10, 13, 2001, 5, 5));
    pending_q.push_back(make_item(10, 24, 2001, 5, 5));
    pending_q.push_back(make_item(10, 25, 2001, 5, 5));
    pending_q.push_back(make_item(31, 4, 2010, 0, 59));
    pending_q.push_back(make_item(1, 1, 8191, 1023, 0));
    pending_q.push_back(make_item(0, 0, 16'h2AAA, 0, 16'hAAAA));
    // Walk across the wrap of the year counter
    pending_q.push_back(make_item(1023, 12, 16383, 0, 0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Four phases of random beats; the sender drains the block between them
    for (int phase = 0; phase < 4; phase++) begin
      while (pending_q.size() != 0 || in_valid_i || instant_q.size() != 0) @(negedge clk_i);
      idle_on = (phase != 3);
      for (int n = 0; n < ((phase == 3) ? 250 : 335); n++) pending_q.push_back(random_item());
    end

    // Wait for the last results, then give the block time to show any stray beat
    while (pending_q.size() != 0 || in_valid_i || instant_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_cnt == 0 && instant_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
